>>> src/spft_pkg.sv
// Shared types and constants for the security policy first-match table.
// No dependencies.
`default_nettype none
package spft_pkg;
  localparam int DEPTH_DEFAULT = 64;
  localparam int ADDR_W = 32;
  localparam int WILD_W = 6;
  localparam int PORT_W = 16;
  localparam int PROTO_W = 8;
  localparam int ID_W = 8;
  localparam int POS_W = 7;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W = 2 * (ADDR_W + WILD_W) + 4 * PORT_W + PROTO_W + ID_W;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_INS, S_REM, S_OUT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [WILD_W-1:0] src_wild;
    logic [ADDR_W-1:0] dst_addr;
    logic [WILD_W-1:0] dst_wild;
    logic [PORT_W-1:0] sp_lo;
    logic [PORT_W-1:0] sp_hi;
    logic [PORT_W-1:0] dp_lo;
    logic [PORT_W-1:0] dp_hi;
    logic [PROTO_W-1:0] proto;
    logic [ID_W-1:0] id;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic rd;        // issue read at scan index
    logic wr_ins;    // write request entry at insert index
    logic shift;     // write previous read data one slot off
    logic step_dn;   // scan index decrement
    logic step_up;   // scan index increment
    logic cnt_inc;
    logic cnt_dec;
    logic set_hit;
    logic set_miss;
    logic set_rej;
    logic set_rem;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ins_ok;
    logic rem_ok;
    logic empty;
    logic rd_valid;  // registered read data is for a live index
    logic hit;
    logic scan_end;  // last index reached
    logic ins_done;
    logic rem_done;
    logic rem_first; // registered read data is the entry being removed
  } stat_t;

  function automatic logic addr_hit(input logic [ADDR_W-1:0] base,
                                    input logic [WILD_W-1:0] wild,
                                    input logic [ADDR_W-1:0] pkt);
    logic [ADDR_W-1:0] m;
    m = (wild >= WILD_W'(ADDR_W)) ? '0 : ~((ADDR_W'(1) << wild) - ADDR_W'(1));
    return (base & m) == (pkt & m);
  endfunction
endpackage
`default_nettype wire

>>> src/spft_ctrl.sv
// Controller state machine for the policy table.
// Depends on spft_pkg.
`default_nettype none
module spft_ctrl import spft_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire logic [1:0] op,
  input  stat_t      st,
  output cmd_t       cmd
);
  state_t state, state_next;
  logic   primed, primed_next; // a read is in flight

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      primed <= 1'b0;
    end else begin
      state  <= state_next;
      primed <= primed_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    primed_next = 1'b0;
    case (state)
      S_IDLE: if (in_valid) begin
        case (op)
          OP_LOOKUP: state_next = S_LOOK;
          OP_INSERT: state_next = S_INS;
          OP_REMOVE: state_next = S_REM;
          default:   state_next = S_OUT;
        endcase
      end
      S_LOOK: begin
        primed_next = 1'b1;
        if (st.empty) state_next = S_OUT;
        else if (primed && st.rd_valid && st.hit) state_next = S_OUT;
        else if (primed && st.scan_end) state_next = S_OUT;
      end
      S_INS: begin
        primed_next = 1'b1;
        if (!st.ins_ok || st.ins_done) state_next = S_OUT;
      end
      S_REM: begin
        primed_next = 1'b1;
        if (!st.rem_ok || (primed && st.rem_done)) state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && op != OP_LOOKUP && op != OP_INSERT && op != OP_REMOVE)
          cmd.set_rej = 1'b1;
      end
      S_LOOK: begin
        if (st.empty) cmd.set_miss = 1'b1;
        else if (primed && st.rd_valid && st.hit) cmd.set_hit = 1'b1;
        else begin
          if (primed && st.scan_end) cmd.set_miss = 1'b1;
          else begin
            cmd.rd      = 1'b1;
            cmd.step_up = primed;
          end
        end
      end
      S_INS: begin
        if (!st.ins_ok) cmd.set_rej = 1'b1;
        else if (st.ins_done) begin
          cmd.wr_ins  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd      = 1'b1;
          cmd.shift   = primed;
          cmd.step_dn = primed;
        end
      end
      S_REM: begin
        if (!st.rem_ok) cmd.set_rej = 1'b1;
        else if (!primed) cmd.rd = 1'b1;  // fetch the entry being removed
        else begin
          // first read back is the removed entry, later ones move up a slot
          if (st.rem_first) cmd.set_rem = 1'b1;
          else cmd.shift = 1'b1;
          if (st.rem_done) cmd.cnt_dec = 1'b1;
          else begin
            cmd.rd      = 1'b1;
            cmd.step_up = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> src/spft_dp.sv
// Datapath: rule memory, scan index, rule count, match logic and result.
// Depends on spft_pkg.
`default_nettype none
module spft_dp import spft_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      cmd,
  output stat_t     st,
  input  wire logic [1:0]          op,
  input  wire logic [POS_W-1:0]    position,
  input  entry_t                   req_in,
  output logic [STATUS_W-1:0]      status,
  output logic [ID_W-1:0]          found_id,
  output logic [POS_W-1:0]         found_position,
  output logic [POS_W-1:0]         rule_count
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  entry_t         mem [DEPTH];
  entry_t         req, rdata;
  logic [XW-1:0]  pos;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx;      // scan or shift index
  logic [CW-1:0]  rd_idx;   // index of rdata
  logic [CW-1:0]  idx_nx;
  logic           op_is_ins;
  logic           cmd_prev_shift;
  logic           hit;

  // scan index after this cycle's step
  always_comb begin
    idx_nx = idx;
    if (cmd.step_dn) idx_nx = idx - CW'(1);
    if (cmd.step_up) idx_nx = idx + CW'(1);
  end

  // request capture and index control
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
      pos <= XW'(position);
      case (op)
        OP_INSERT: idx <= (count == '0) ? '0 : count - CW'(1);
        OP_REMOVE: idx <= (position == '0) ? '0 : CW'(XW'(position) - XW'(1));
        default:   idx <= '0;
      endcase
    end else idx <= idx_nx;
  end

  // memory read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata  <= mem[idx_nx[IW-1:0]];
      rd_idx <= idx_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) op_is_ins <= (op == OP_INSERT);
  end

  // memory write: shifted entry or new rule
  always_ff @(posedge clk) begin
    if (cmd.wr_ins)
      mem[IW'(pos - XW'(1))] <= req;
    else if (cmd.shift) begin
      if (op_is_ins) mem[IW'(rd_idx + CW'(1))] <= rdata;
      else           mem[IW'(rd_idx - CW'(1))] <= rdata;
    end
  end

  // rule count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.cnt_inc) count <= count + CW'(1);
    else if (cmd.cnt_dec) count <= count - CW'(1);
  end

  // match of the registered entry against the packet
  always_comb begin
    hit = addr_hit(rdata.src_addr, rdata.src_wild, req.src_addr)
       && addr_hit(rdata.dst_addr, rdata.dst_wild, req.dst_addr)
       && (req.sp_lo >= rdata.sp_lo) && (req.sp_lo <= rdata.sp_hi)
       && (req.dp_lo >= rdata.dp_lo) && (req.dp_lo <= rdata.dp_hi)
       && (req.proto == rdata.proto);
  end

  // tracks that index 0 has already been moved on insert
  always_ff @(posedge clk) begin
    if (rst || cmd.load) cmd_prev_shift <= 1'b0;
    else if (cmd.shift && rd_idx == '0) cmd_prev_shift <= 1'b1;
  end

  // status toward the controller
  always_comb begin
    st.ins_ok    = (pos != '0) && (pos <= XW'(count) + XW'(1))
                && (XW'(count) < XW'(DEPTH));
    st.rem_ok    = (pos != '0) && (pos <= XW'(count));
    st.empty     = (count == '0);
    st.rd_valid  = (rd_idx < count);
    st.hit       = hit;
    st.scan_end  = (rd_idx + CW'(1) >= count);
    // insert: done when next slot to move is below insert point
    st.ins_done  = (XW'(count) < pos) || (XW'(idx) + XW'(1) < pos) || cmd_prev_shift;
    // remove: done once the entry in rdata is the last one
    st.rem_done  = (XW'(rd_idx) + XW'(1) >= XW'(count));
    st.rem_first = (XW'(rd_idx) + XW'(1) == pos);
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_id       <= '0;
      found_position <= '0;
    end
    if (cmd.set_hit) begin
      status         <= ST_DONE;
      found_id       <= rdata.id;
      found_position <= POS_W'(rd_idx + CW'(1));
    end
    if (cmd.set_miss) status <= ST_MISS;
    if (cmd.set_rej)  status <= ST_REJECT;
    if (cmd.cnt_inc)  status <= ST_DONE;
    if (cmd.set_rem) begin
      status         <= ST_DONE;
      found_id       <= rdata.id;
      found_position <= POS_W'(pos);
    end
  end

  assign rule_count = POS_W'(count);
endmodule
`default_nettype wire

>>> src/security_policy_first_match_table_unit.sv
// Top level of the security policy first-match table.
// Depends on spft_pkg, spft_ctrl, spft_dp.
//
// channel   direction  handshake           payload
// request   in         in_valid/in_stall   operation..protocol
// result    out        out_valid/out_stall status, found_id, found_position, rule_count
//
// A lookup reads one rule per cycle from the rule memory.
// Insert and remove move one entry per cycle through the rule memory.
// One request is worked at a time.
// Reset clears the rule count; rule memory contents are unused until written.
// A stalled result holds; no new request is taken until it leaves.
`default_nettype none
module security_policy_first_match_table_unit import spft_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [1:0]           operation,
  input  wire logic [POS_W-1:0]     position,
  input  wire logic [ID_W-1:0]      rule_id,
  input  wire logic [ADDR_W-1:0]    src_addr,
  input  wire logic [WILD_W-1:0]    src_wild_bits,
  input  wire logic [ADDR_W-1:0]    dst_addr,
  input  wire logic [WILD_W-1:0]    dst_wild_bits,
  input  wire logic [PORT_W-1:0]    src_port_lo,
  input  wire logic [PORT_W-1:0]    src_port_hi,
  input  wire logic [PORT_W-1:0]    dst_port_lo,
  input  wire logic [PORT_W-1:0]    dst_port_hi,
  input  wire logic [PROTO_W-1:0]   protocol,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [ID_W-1:0]           found_id,
  output logic [POS_W-1:0]          found_position,
  output logic [POS_W-1:0]          rule_count
);
  cmd_t   cmd;
  stat_t  st;
  entry_t req_in;

  assign req_in = '{src_addr: src_addr, src_wild: src_wild_bits,
                    dst_addr: dst_addr, dst_wild: dst_wild_bits,
                    sp_lo: src_port_lo, sp_hi: src_port_hi,
                    dp_lo: dst_port_lo, dp_hi: dst_port_hi,
                    proto: protocol, id: rule_id};

  spft_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .op(operation), .st, .cmd
  );

  spft_dp #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst, .cmd, .st, .op(operation), .position, .req_in,
    .status, .found_id, .found_position, .rule_count
  );

  // a request is only taken while no result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken with result pending");

  // count never exceeds depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    rule_count <= POS_W'(DEPTH)) else $error("rule count overflow");

  // a rejected request leaves the count alone
  a_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status == ST_REJECT |-> $stable(rule_count))
    else $error("rejected request changed count");
endmodule
`default_nettype wire
